// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps
// deq_pkg: shared widths, opcodes, status codes and control structs
// for the double-ended queue core; no dependencies

package deq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 11;
    localparam int CNT_W     = 11;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic accept;
        logic rd_done;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_read;
    } t_dp_sts;

endpackage

// ===== sv/deq_ram.sv =====
`timescale 1ns / 1ps
// deq_ram: generic one-write one-read RAM with registered read data
// no dependencies

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/deq_ctrl.sv =====
`timescale 1ns / 1ps
// deq_ctrl: handshake and sequencing state machine of the deque core
// depends on deq_pkg

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  deq_pkg::t_dp_sts i_sts,
    output deq_pkg::t_dp_cmd o_cmd
);

    import deq_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_READ = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_stall;
    logic       accept;

    assign in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept   = i_in_valid && !in_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.pop_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.accept  = accept;
    assign o_cmd.rd_done = (r_state == S_READ);

endmodule

// ===== sv/deq_dp.sv =====
`timescale 1ns / 1ps
// deq_dp: head pointer, entry count, capacity register, slot RAM and result registers
// depends on deq_pkg and deq_ram

module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  deq_pkg::t_dp_cmd                     i_cmd,
    output deq_pkg::t_dp_sts                     o_sts,
    input  logic                                 i_cfg_we,
    input  logic [deq_pkg::CAP_W-1:0]            i_cfg_wdata,
    output logic [deq_pkg::CAP_W-1:0]            o_capacity,
    input  logic [deq_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]    i_push_value,
    output logic signed [deq_pkg::DATA_W-1:0]    o_pop_value,
    output logic [deq_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_is_empty,
    output logic                                 o_is_full,
    output logic [deq_pkg::CNT_W-1:0]            o_entry_count
);

    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] EFF_RESET =
        (int'(CAP_RESET) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [CAP_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_eff_cap;
    logic [PTR_W-1:0]        r_head;
    logic [PTR_W-1:0]        n_head;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [STATUS_W-1:0]     n_status;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_is_empty;
    logic                    r_is_full;
    logic [CNT_W-1:0]        r_entry_count;
    logic signed [DATA_W-1:0] r_pop_value;
    logic                    full;
    logic                    empty;
    logic                    we;
    logic [PTR_W-1:0]        waddr;
    logic [PTR_W-1:0]        raddr;
    logic                    pop_ok;
    logic [DATA_W-1:0]       rdata;

    assign full  = r_count >= r_eff_cap;
    assign empty = r_count == '0;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = STATUS_OK;
        we       = 1'b0;
        waddr    = wrap_add(r_head, r_count);
        raddr    = r_head;
        pop_ok   = 1'b0;
        case (i_opcode)
            OP_PUSH_REAR: begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_head  = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
                    waddr   = n_head;
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    pop_ok  = 1'b1;
                    n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    pop_ok  = 1'b1;
                    raddr   = wrap_add(r_head, r_count - CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.accept),
        .i_waddr (waddr),
        .i_wdata (i_push_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_cap     <= CAP_RESET;
            r_eff_cap <= EFF_RESET;
        end else begin
            if (i_cmd.accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap     <= i_cfg_wdata;
                r_eff_cap <= (int'(i_cfg_wdata) > DEPTH) ? CNT_W'(DEPTH) : i_cfg_wdata;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status      <= n_status;
            r_is_empty    <= (n_count == '0);
            r_is_full     <= (n_count >= r_eff_cap);
            r_entry_count <= n_count;
            r_pop_value   <= '0;
        end else if (i_cmd.rd_done) begin
            r_pop_value   <= rdata;
        end
    end

    assign o_sts.pop_read = pop_ok;
    assign o_capacity     = r_cap;
    assign o_pop_value    = r_pop_value;
    assign o_status       = r_status;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;
    assign o_entry_count  = r_entry_count;

endmodule

// ===== sv/double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// double_ended_queue_core: top level of the bounded deque with APB capacity register
// depends on deq_pkg, deq_ctrl, deq_dp
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-------------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_opcode, i_push_value
//  output  | o_out_valid  | i_out_stall  | o_pop_value, o_status, o_is_empty,
//          |              |              | o_is_full, o_entry_count
//
//  a push or a refused operation answers directly from IDLE, a successful pop passes
//  through the READ state, which waits for the registered read of the slot RAM
//  o_in_stall is high in the read cycle of a pop and while a result beat is stalled
//  reset clears head pointer, count and handshake state; capacity returns to 1024
//  slot contents are not cleared and are only read after being written

module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [deq_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]    i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [deq_pkg::DATA_W-1:0]    o_pop_value,
    output logic [deq_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_is_empty,
    output logic                                 o_is_full,
    output logic [deq_pkg::CNT_W-1:0]            o_entry_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [deq_pkg::PADDR_W-1:0]          paddr,
    input  logic [deq_pkg::PDATA_W-1:0]          pwdata,
    output logic [deq_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    import deq_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             cfg_we;
    logic [CAP_W-1:0] capacity;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_CAPACITY);
    assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (pwdata[CAP_W-1:0]),
        .o_capacity    (capacity),
        .i_opcode      (i_opcode),
        .i_push_value  (i_push_value),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_entry_count (o_entry_count)
    );

endmodule

// ===== sv/deq_checker.sv =====
`timescale 1ns / 1ps
// deq_checker: port-level checks on result beats of the deque core, bound to the top level
// depends on deq_pkg and double_ended_queue_core

module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [deq_pkg::DATA_W-1:0] o_pop_value,
    input logic [deq_pkg::STATUS_W-1:0]      o_status,
    input logic                              o_is_empty,
    input logic                              o_is_full,
    input logic [deq_pkg::CNT_W-1:0]         o_entry_count
);

    import deq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pop_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result beat changed");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_FULL) |-> o_is_full)
        else $error("refused push without full flag");

    a_empty_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_EMPTY) |->
            o_is_empty && (o_entry_count == '0) && (o_pop_value == '0))
        else $error("refused pop with entries or data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
